// File: sv/hvls_pkg.sv
// Shared constants, types and saturating add for the HMM Viterbi log scorer.
package hvls_pkg;

    localparam int MAX_STATES   = 16;
    localparam int SYMBOL_COUNT = 16;

    localparam int SCORE_W = 32;
    localparam int ENTRY_W = 16;
    localparam int SW      = $clog2(MAX_STATES);
    localparam int NW      = $clog2(MAX_STATES + 1);
    localparam int TAW     = $clog2(MAX_STATES * MAX_STATES);
    localparam int EAW     = $clog2(MAX_STATES * SYMBOL_COUNT);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int CFG_W     = 5;

    localparam logic signed [SCORE_W-1:0] FLOOR_SCORE = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [ENTRY_W-1:0] ZERO_PROB   = {1'b1, {(ENTRY_W-1){1'b0}}};

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_OBSERVE  = 3'd1;
    localparam logic [2:0] OP_WR_TRANS = 3'd2;
    localparam logic [2:0] OP_WR_EMIS  = 3'd3;
    localparam logic [2:0] OP_WR_START = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_OBS    = 6'b000100,
        ST_COMMIT = 6'b001000,
        ST_SCAN   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    function automatic logic signed [SCORE_W-1:0] add_sat(
        input logic signed [SCORE_W-1:0] score,
        input logic signed [ENTRY_W-1:0] entry
    );
        logic [SCORE_W:0] sum;
        sum = {score[SCORE_W-1], score} + {{(SCORE_W-ENTRY_W+1){entry[ENTRY_W-1]}}, entry};
        if (score == FLOOR_SCORE || entry == ZERO_PROB) begin
            return FLOOR_SCORE;
        end else if (sum[SCORE_W] != sum[SCORE_W-1]) begin
            return FLOOR_SCORE;
        end else begin
            return sum[SCORE_W-1:0];
        end
    endfunction

endpackage

// File: sv/hvls_ram.sv
// Generic simple dual-port RAM with registered read.
module hvls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: sv/hmm_viterbi_log_scorer.sv
// One add-compare unit visits one source-destination pair per cycle, then one
// comparator scans the n path scores for the best one, where n is the clamped
// active state count. One transaction at a time.
// Reset: synchronous active-low; path score 0 and start entry 0 are zero, the rest
// impossible, active_states is 16; transition and emission tables keep old contents.
module hmm_viterbi_log_scorer
    import hvls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // symbol[3:0], row[7:4], col[11:8], value[27:12], zero[31:28]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // score[31:0], best_state[35:32], zero[39:36]
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] active_reg;
    logic [NW-1:0]    n_cnt;
    logic [SW-1:0]    n_last;

    logic [2:0]                op_reg, op_next;
    logic [3:0]                sym_reg, sym_next;
    logic [3:0]                row_reg, row_next;
    logic [3:0]                col_reg, col_next;
    logic signed [ENTRY_W-1:0] val_reg, val_next;

    logic signed [SCORE_W-1:0] path_reg  [MAX_STATES];
    logic signed [SCORE_W-1:0] path_next [MAX_STATES];
    logic signed [SCORE_W-1:0] fresh_reg [MAX_STATES];
    logic signed [SCORE_W-1:0] fresh_next[MAX_STATES];
    logic signed [ENTRY_W-1:0] start_reg [MAX_STATES];
    logic signed [ENTRY_W-1:0] start_next[MAX_STATES];

    logic          issue_on_reg, issue_on_next;
    logic [SW-1:0] s_cnt_reg, s_cnt_next;
    logic [SW-1:0] d_cnt_reg, d_cnt_next;

    logic                      p_valid_reg, p_valid_next;
    logic                      p_first_reg, p_first_next;
    logic                      p_last_reg, p_last_next;
    logic [SW-1:0]             p_d_reg, p_d_next;
    logic signed [SCORE_W-1:0] p_score_reg, p_score_next;
    logic signed [SCORE_W-1:0] acc_best_reg, acc_best_next;
    logic signed [ENTRY_W-1:0] emis_hold_reg, emis_hold_next;

    logic                      f_valid_reg, f_valid_next;
    logic [SW-1:0]             f_d_reg, f_d_next;
    logic signed [SCORE_W-1:0] f_best_reg, f_best_next;

    logic [SW-1:0]             scan_i_reg, scan_i_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [SW-1:0]             best_idx_reg, best_idx_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic signed [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [3:0]                out_state_reg, out_state_next;

    logic            trans_we, trans_re, emis_we, emis_re;
    logic [TAW-1:0]  trans_waddr, trans_raddr;
    logic [EAW-1:0]  emis_waddr, emis_raddr;
    logic [ENTRY_W-1:0] trans_rdata, emis_rdata;

    logic signed [SCORE_W-1:0] cand;
    logic signed [SCORE_W-1:0] base;
    logic signed [SCORE_W-1:0] new_best;
    logic                      sym_ok;
    logic                      row_ok;
    logic                      trans_col_ok;
    logic                      emis_col_ok;

    always_comb begin
        if (active_reg == '0) begin
            n_cnt = NW'(1);
        end else if (32'(active_reg) > MAX_STATES) begin
            n_cnt = NW'(MAX_STATES);
        end else begin
            n_cnt = NW'(active_reg);
        end
    end

    assign n_last       = SW'(n_cnt - NW'(1));
    assign sym_ok       = 32'(sym_reg) < SYMBOL_COUNT;
    assign row_ok       = 32'(row_reg) < MAX_STATES;
    assign trans_col_ok = 32'(col_reg) < MAX_STATES;
    assign emis_col_ok  = 32'(col_reg) < SYMBOL_COUNT;

    assign trans_waddr = TAW'(row_reg) * TAW'(MAX_STATES) + TAW'(col_reg);
    assign emis_waddr  = EAW'(row_reg) * EAW'(SYMBOL_COUNT) + EAW'(col_reg);
    assign trans_raddr = TAW'(s_cnt_reg) * TAW'(MAX_STATES) + TAW'(d_cnt_reg);
    assign emis_raddr  = EAW'(d_cnt_reg) * EAW'(SYMBOL_COUNT) + EAW'(sym_reg);

    assign cand     = add_sat(p_score_reg, trans_rdata);
    assign base     = p_first_reg ? FLOOR_SCORE : acc_best_reg;
    assign new_best = (cand > base) ? cand : base;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        sym_next       = sym_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        val_next       = val_reg;
        path_next      = path_reg;
        fresh_next     = fresh_reg;
        start_next     = start_reg;
        issue_on_next  = issue_on_reg;
        s_cnt_next     = s_cnt_reg;
        d_cnt_next     = d_cnt_reg;
        p_valid_next   = 1'b0;
        p_first_next   = p_first_reg;
        p_last_next    = p_last_reg;
        p_d_next       = p_d_reg;
        p_score_next   = p_score_reg;
        acc_best_next  = acc_best_reg;
        emis_hold_next = emis_hold_reg;
        f_valid_next   = 1'b0;
        f_d_next       = f_d_reg;
        f_best_next    = f_best_reg;
        scan_i_next    = scan_i_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_score_next = out_score_reg;
        out_state_next = out_state_reg;
        trans_we       = 1'b0;
        trans_re       = 1'b0;
        emis_we        = 1'b0;
        emis_re        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[2:0];
                    sym_next   = s_tdata[3:0];
                    row_next   = s_tdata[7:4];
                    col_next   = s_tdata[11:8];
                    val_next   = s_tdata[27] ? s_tdata[27:12] : '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                scan_i_next   = '0;
                best_next     = FLOOR_SCORE;
                best_idx_next = '0;
                state_next    = ST_SCAN;
                case (op_reg)
                    OP_START: begin
                        for (int i = 0; i < MAX_STATES; i++) begin
                            path_next[i] = (start_reg[i] == ZERO_PROB) ? FLOOR_SCORE :
                                           SCORE_W'(start_reg[i]);
                        end
                    end
                    OP_OBSERVE: begin
                        for (int i = 0; i < MAX_STATES; i++) begin
                            fresh_next[i] = FLOOR_SCORE;
                        end
                        s_cnt_next = '0;
                        d_cnt_next = '0;
                        if (sym_ok) begin
                            issue_on_next = 1'b1;
                            state_next    = ST_OBS;
                        end else begin
                            state_next = ST_COMMIT;
                        end
                    end
                    OP_WR_TRANS: begin
                        trans_we = row_ok && trans_col_ok;
                    end
                    OP_WR_EMIS: begin
                        emis_we = row_ok && emis_col_ok;
                    end
                    OP_WR_START: begin
                        if (row_ok) begin
                            start_next[SW'(row_reg)] = val_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_OBS: begin
                if (issue_on_reg) begin
                    trans_re     = 1'b1;
                    emis_re      = (s_cnt_reg == '0);
                    p_valid_next = 1'b1;
                    p_score_next = path_reg[s_cnt_reg];
                    p_first_next = (s_cnt_reg == '0);
                    p_last_next  = (s_cnt_reg == n_last);
                    p_d_next     = d_cnt_reg;
                    if (s_cnt_reg == n_last) begin
                        s_cnt_next = '0;
                        if (d_cnt_reg == n_last) begin
                            issue_on_next = 1'b0;
                        end else begin
                            d_cnt_next = d_cnt_reg + SW'(1);
                        end
                    end else begin
                        s_cnt_next = s_cnt_reg + SW'(1);
                    end
                end
                if (p_valid_reg) begin
                    acc_best_next = new_best;
                    if (p_first_reg) begin
                        emis_hold_next = emis_rdata;
                    end
                    if (p_last_reg) begin
                        f_valid_next = 1'b1;
                        f_best_next  = new_best;
                        f_d_next     = p_d_reg;
                    end
                end
                if (f_valid_reg) begin
                    fresh_next[f_d_reg] = add_sat(f_best_reg, emis_hold_reg);
                    if (f_d_reg == n_last) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                path_next  = fresh_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (path_reg[scan_i_reg] > best_reg) begin
                    best_next     = path_reg[scan_i_reg];
                    best_idx_next = scan_i_reg;
                end
                if (scan_i_reg == n_last) begin
                    state_next = ST_DONE;
                end else begin
                    scan_i_next = scan_i_reg + SW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    out_score_next = best_reg;
                    out_state_next = 4'(best_idx_reg);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= CFG_W'(MAX_STATES);
            issue_on_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_STATES; i++) begin
                path_reg[i]  <= (i == 0) ? '0 : FLOOR_SCORE;
                start_reg[i] <= (i == 0) ? '0 : ZERO_PROB;
            end
        end else begin
            state_reg    <= state_next;
            issue_on_reg <= issue_on_next;
            p_valid_reg  <= p_valid_next;
            f_valid_reg  <= f_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            path_reg     <= path_next;
            start_reg    <= start_next;
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        sym_reg       <= sym_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        val_reg       <= val_next;
        fresh_reg     <= fresh_next;
        s_cnt_reg     <= s_cnt_next;
        d_cnt_reg     <= d_cnt_next;
        p_first_reg   <= p_first_next;
        p_last_reg    <= p_last_next;
        p_d_reg       <= p_d_next;
        p_score_reg   <= p_score_next;
        acc_best_reg  <= acc_best_next;
        emis_hold_reg <= emis_hold_next;
        f_d_reg       <= f_d_next;
        f_best_reg    <= f_best_next;
        scan_i_reg    <= scan_i_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        out_score_reg <= out_score_next;
        out_state_reg <= out_state_next;
    end

    hvls_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_STATES * MAX_STATES)
    ) u_trans_ram (
        .aclk (aclk),
        .we   (trans_we),
        .waddr(trans_waddr),
        .wdata(val_reg),
        .re   (trans_re),
        .raddr(trans_raddr),
        .rdata(trans_rdata)
    );

    hvls_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_STATES * SYMBOL_COUNT)
    ) u_emis_ram (
        .aclk (aclk),
        .we   (emis_we),
        .waddr(emis_waddr),
        .wdata(val_reg),
        .re   (emis_re),
        .raddr(emis_raddr),
        .rdata(emis_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_state_reg, out_score_reg};

endmodule

// File: sv/hvls_checker.sv
// Port-level checker for the HMM Viterbi log scorer and its bind.
module hvls_checker
    import hvls_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_wr_en,
    input logic [CFG_W-1:0]     cfg_wr_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    a_score_not_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31] || m_tdata[31:0] == 32'd0))
        else $error("reported score is positive");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the result channel");

endmodule

bind hmm_viterbi_log_scorer hvls_checker u_hvls_checker (.*);
